FILE: rtl/core/gba_pkg.sv
// Shared types, constants and tables for the Goertzel bin analyser.
// Used by every module in rtl/core; depends on nothing else.
package gba_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned MaxBlockDef   = 4096;
  localparam int unsigned DelayWidthDef = 48;

  // Fixed field widths.
  localparam int unsigned SampleW   = 16;
  localparam int unsigned BlockLenW = 13;
  localparam int unsigned CoefW     = 18;
  localparam int unsigned PartW     = 48;
  localparam int unsigned MagW      = 47;
  localparam int unsigned PhaseW    = 16;
  localparam int unsigned FracW     = 16;

  // Shared multiplier: signed 25 x 25, operands cut into 24-bit chunks.
  localparam int unsigned ChunkW = 24;
  localparam int unsigned MulW   = ChunkW + 1;
  localparam int unsigned ProdW  = 2 * MulW;

  // Sequencer counts.
  localparam int unsigned IdxW        = 3;
  localparam int unsigned StepW       = 6;
  localparam int unsigned SqSteps     = 8;
  localparam int unsigned SqrtSteps   = PartW;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CordicW     = PartW + 3;
  localparam int unsigned AngleW      = 25;

  // Phase constants in 1/256 centidegree and in centidegrees.
  localparam int HalfTurn = 18000 * 256;
  localparam int PhaseMax = 18000;

  // Configuration port.
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  typedef enum logic [1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_COSINE_TERM  = 2'd1,
    REG_SINE_TERM    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    MUL_REC,
    MUL_RE,
    MUL_IM,
    MUL_SQ
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_MUL,
    ST_REC_WAIT,
    ST_REC_END,
    ST_RE_MUL,
    ST_RE_WAIT,
    ST_RE_END,
    ST_IM_MUL,
    ST_IM_WAIT,
    ST_IM_END,
    ST_SQ_MUL,
    ST_SQ_WAIT,
    ST_SQ_END,
    ST_ROOT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [BlockLenW-1:0]    block_length;
    logic signed [CoefW-1:0] cosine_term;
    logic signed [CoefW-1:0] sine_term;
  } cfg_t;

  typedef struct packed {
    logic            load_sample;
    logic            mul_en;
    mul_sel_e        mul_sel;
    logic [IdxW-1:0] idx;
    logic            acc_clr;
    logic            rec_upd;
    logic            re_upd;
    logic            im_upd;
    logic            sq_upd;
    logic            root_en;
    logic            cordic_en;
    logic [3:0]      cordic_i;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  // CORDIC arctangent table in 1/256 centidegree.
  function automatic logic [20:0] atan_lut(input logic [3:0] i);
    logic [20:0] v;
    unique case (i)
      4'd0:  v = 21'd1152000;
      4'd1:  v = 21'd680065;
      4'd2:  v = 21'd359328;
      4'd3:  v = 21'd182400;
      4'd4:  v = 21'd91554;
      4'd5:  v = 21'd45822;
      4'd6:  v = 21'd22916;
      4'd7:  v = 21'd11459;
      4'd8:  v = 21'd5730;
      4'd9:  v = 21'd2865;
      4'd10: v = 21'd1432;
      4'd11: v = 21'd716;
      4'd12: v = 21'd358;
      4'd13: v = 21'd179;
      4'd14: v = 21'd90;
      4'd15: v = 21'd45;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/gba_regs.sv
// Configuration register file with an APB-style access port.
// Depends on gba_pkg for the register map and the configuration struct.
module gba_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gba_pkg::PaddrW-1:0]  paddr,
  input  logic [gba_pkg::PdataW-1:0]  pwdata,
  output logic [gba_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  output gba_pkg::cfg_t               cfg_o
);

  gba_pkg::cfg_t     cfg_q;
  gba_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = gba_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_o   = cfg_q;

  // Register writes; addresses beyond the map are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_length <= gba_pkg::BlockLenW'(256);
      cfg_q.cosine_term  <= gba_pkg::CoefW'(65536);
      cfg_q.sine_term    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        gba_pkg::REG_BLOCK_LENGTH: cfg_q.block_length <= pwdata[gba_pkg::BlockLenW-1:0];
        gba_pkg::REG_COSINE_TERM:  cfg_q.cosine_term  <= pwdata[gba_pkg::CoefW-1:0];
        gba_pkg::REG_SINE_TERM:    cfg_q.sine_term    <= pwdata[gba_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register bits.
  always_comb begin
    unique case (reg_idx)
      gba_pkg::REG_BLOCK_LENGTH: prdata = gba_pkg::PdataW'(cfg_q.block_length);
      gba_pkg::REG_COSINE_TERM:  prdata = gba_pkg::PdataW'(unsigned'(cfg_q.cosine_term));
      gba_pkg::REG_SINE_TERM:    prdata = gba_pkg::PdataW'(unsigned'(cfg_q.sine_term));
      default:                   prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/gba_ctrl.sv
// Sequencer of the Goertzel bin analyser: issues datapath commands per item.
// Depends on gba_pkg for the state enum and the command and status structs.
module gba_ctrl #(
  parameter int unsigned DELAY_WIDTH = gba_pkg::DelayWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  input  gba_pkg::sts_t sts_i,
  output gba_pkg::cmd_t cmd_o
);

  localparam int unsigned NumChunks = (DELAY_WIDTH + gba_pkg::ChunkW - 1) / gba_pkg::ChunkW;
  localparam logic [gba_pkg::StepW-1:0] ChunkLast  = gba_pkg::StepW'(NumChunks - 1);
  localparam logic [gba_pkg::StepW-1:0] SqLast     = gba_pkg::StepW'(gba_pkg::SqSteps - 1);
  localparam logic [gba_pkg::StepW-1:0] RootLast   = gba_pkg::StepW'(gba_pkg::SqrtSteps - 1);
  localparam logic [gba_pkg::StepW-1:0] CordicLen  = gba_pkg::StepW'(gba_pkg::CordicSteps);

  gba_pkg::state_e             state_q, state_d;
  logic [gba_pkg::StepW-1:0]   step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  logic [gba_pkg::StepW-1:0]   step_inc;

  assign step_inc = step_q + gba_pkg::StepW'(1);

  // Next state and step counter.
  always_comb begin
    state_d = state_q;
    step_d  = '0;
    unique case (state_q)
      gba_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = gba_pkg::ST_REC_MUL;
      end
      gba_pkg::ST_REC_MUL: begin
        if (step_q == ChunkLast) state_d = gba_pkg::ST_REC_WAIT;
        else step_d = step_inc;
      end
      gba_pkg::ST_REC_WAIT: state_d = gba_pkg::ST_REC_END;
      gba_pkg::ST_REC_END: begin
        state_d = sts_i.last ? gba_pkg::ST_RE_MUL : gba_pkg::ST_IDLE;
      end
      gba_pkg::ST_RE_MUL: begin
        if (step_q == ChunkLast) state_d = gba_pkg::ST_RE_WAIT;
        else step_d = step_inc;
      end
      gba_pkg::ST_RE_WAIT: state_d = gba_pkg::ST_RE_END;
      gba_pkg::ST_RE_END:  state_d = gba_pkg::ST_IM_MUL;
      gba_pkg::ST_IM_MUL: begin
        if (step_q == ChunkLast) state_d = gba_pkg::ST_IM_WAIT;
        else step_d = step_inc;
      end
      gba_pkg::ST_IM_WAIT: state_d = gba_pkg::ST_IM_END;
      gba_pkg::ST_IM_END:  state_d = gba_pkg::ST_SQ_MUL;
      gba_pkg::ST_SQ_MUL: begin
        if (step_q == SqLast) state_d = gba_pkg::ST_SQ_WAIT;
        else step_d = step_inc;
      end
      gba_pkg::ST_SQ_WAIT: state_d = gba_pkg::ST_SQ_END;
      gba_pkg::ST_SQ_END:  state_d = gba_pkg::ST_ROOT;
      gba_pkg::ST_ROOT: begin
        if (step_q == RootLast) state_d = gba_pkg::ST_EMIT;
        else step_d = step_inc;
      end
      gba_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) state_d = gba_pkg::ST_IDLE;
      end
      default: state_d = gba_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = gba_pkg::MUL_REC;
    cmd_o.idx       = step_q[gba_pkg::IdxW-1:0];
    cmd_o.cordic_i  = step_q[3:0];
    unique case (state_q)
      gba_pkg::ST_IDLE:    cmd_o.load_sample = in_valid_i;
      gba_pkg::ST_REC_MUL: cmd_o.mul_en = 1'b1;
      gba_pkg::ST_RE_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gba_pkg::MUL_RE;
      end
      gba_pkg::ST_IM_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gba_pkg::MUL_IM;
      end
      gba_pkg::ST_SQ_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gba_pkg::MUL_SQ;
      end
      gba_pkg::ST_REC_END: begin
        cmd_o.rec_upd = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      gba_pkg::ST_RE_END: begin
        cmd_o.re_upd  = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      gba_pkg::ST_IM_END: begin
        cmd_o.im_upd  = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      gba_pkg::ST_SQ_END: begin
        cmd_o.sq_upd  = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      gba_pkg::ST_ROOT: begin
        cmd_o.root_en   = 1'b1;
        cmd_o.cordic_en = (step_q < CordicLen);
      end
      gba_pkg::ST_EMIT: cmd_o.out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // The output register stays full until the item is taken.
  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != gba_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gba_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/gba_dp.sv
// Datapath of the Goertzel bin analyser: delays, shared multiplier and
// accumulator, bit-serial square root, CORDIC phase and output registers.
// Depends on gba_pkg; driven by gba_ctrl through the command struct.
module gba_dp #(
  parameter int unsigned MAX_BLOCK   = gba_pkg::MaxBlockDef,
  parameter int unsigned DELAY_WIDTH = gba_pkg::DelayWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gba_pkg::cfg_t                      cfg_i,
  input  logic signed [gba_pkg::SampleW-1:0] sample_i,
  input  gba_pkg::cmd_t                      cmd_i,
  output gba_pkg::sts_t                      sts_o,
  output logic signed [gba_pkg::PartW-1:0]   real_part_o,
  output logic signed [gba_pkg::PartW-1:0]   imag_part_o,
  output logic [gba_pkg::MagW-1:0]           magnitude_o,
  output logic signed [gba_pkg::PhaseW-1:0]  phase_centideg_o
);

  localparam int unsigned NumChunks = (DELAY_WIDTH + gba_pkg::ChunkW - 1) / gba_pkg::ChunkW;
  localparam int unsigned ExtW  = NumChunks * gba_pkg::ChunkW;
  localparam int unsigned AccW  = (ExtW + 20 > 98) ? ExtW + 20 : 98;
  localparam int unsigned SumW  = AccW + 1;
  localparam int unsigned CntW  = $clog2(MAX_BLOCK);
  localparam int unsigned CmpW  = ((CntW > gba_pkg::BlockLenW) ? CntW : gba_pkg::BlockLenW) + 1;
  localparam int unsigned RootW = gba_pkg::PartW;
  localparam int unsigned RadW  = 2 * RootW;
  localparam int unsigned RemW  = RootW + 2;
  localparam int unsigned PW    = gba_pkg::PartW;
  localparam int unsigned CW    = gba_pkg::CordicW;
  localparam int unsigned AW    = gba_pkg::AngleW;

  // Recurrence state.
  logic signed [DELAY_WIDTH-1:0]      d1_q, d2_q;
  logic [CntW-1:0]                    cnt_q;
  logic signed [gba_pkg::SampleW-1:0] sample_q;

  // Block length clamp and end-of-block detection.
  logic [CmpW-1:0] len_raw, eff_len, cnt_next;

  always_comb begin
    len_raw = CmpW'(cfg_i.block_length);
    if (len_raw == '0) eff_len = CmpW'(1);
    else if (len_raw > CmpW'(MAX_BLOCK)) eff_len = CmpW'(MAX_BLOCK);
    else eff_len = len_raw;
  end

  assign cnt_next   = CmpW'(cnt_q) + CmpW'(1);
  assign sts_o.last = (cnt_next >= eff_len);

  // Multiplier operand selection.
  logic signed [ExtW-1:0]             d1_ext, d2_ext, dsel_ext;
  logic [gba_pkg::ChunkW-1:0]         d_chunk, sq_a, sq_b;
  logic [1:0]                         chunk_k;
  logic signed [gba_pkg::CoefW:0]     coef2;
  logic [PW-1:0]                      mag_re, mag_im, mag_sel;
  logic signed [gba_pkg::MulW-1:0]    op_a, op_b;
  logic [1:0]                         op_sh;
  logic signed [PW-1:0]               re_q, im_q;

  assign d1_ext   = ExtW'(d1_q);
  assign d2_ext   = ExtW'(d2_q);
  assign chunk_k  = cmd_i.idx[1:0];
  assign dsel_ext = (cmd_i.mul_sel == gba_pkg::MUL_REC) ? d1_ext : d2_ext;
  assign d_chunk  = dsel_ext[chunk_k * gba_pkg::ChunkW +: gba_pkg::ChunkW];
  assign coef2    = {cfg_i.cosine_term, 1'b0};
  assign mag_re   = re_q[PW-1] ? PW'(-re_q) : re_q;
  assign mag_im   = im_q[PW-1] ? PW'(-im_q) : im_q;
  assign mag_sel  = cmd_i.idx[2] ? mag_im : mag_re;
  assign sq_a     = cmd_i.idx[0] ? mag_sel[PW-1:gba_pkg::ChunkW] : mag_sel[gba_pkg::ChunkW-1:0];
  assign sq_b     = cmd_i.idx[1] ? mag_sel[PW-1:gba_pkg::ChunkW] : mag_sel[gba_pkg::ChunkW-1:0];

  always_comb begin
    // The top chunk of a delay carries its sign; lower chunks are unsigned.
    if (32'(chunk_k) == NumChunks - 1) op_b = {d_chunk[gba_pkg::ChunkW-1], d_chunk};
    else op_b = {1'b0, d_chunk};
    op_sh = chunk_k;
    unique case (cmd_i.mul_sel)
      gba_pkg::MUL_REC: op_a = gba_pkg::MulW'(coef2);
      gba_pkg::MUL_RE:  op_a = gba_pkg::MulW'(cfg_i.cosine_term);
      gba_pkg::MUL_IM:  op_a = gba_pkg::MulW'(cfg_i.sine_term);
      gba_pkg::MUL_SQ: begin
        op_a  = {1'b0, sq_a};
        op_b  = {1'b0, sq_b};
        op_sh = {1'b0, cmd_i.idx[0]} + {1'b0, cmd_i.idx[1]};
      end
      default: op_a = '0;
    endcase
  end

  // Registered product, then shifted accumulation in the following cycle.
  logic signed [gba_pkg::ProdW-1:0] prod_q;
  logic [1:0]                       prod_sh_q;
  logic                             prod_v_q;
  logic signed [AccW-1:0]           acc_q, addend, acc_sh;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q    <= op_a * op_b;
      prod_sh_q <= op_sh;
    end
  end

  assign addend = AccW'(prod_q) <<< (prod_sh_q * gba_pkg::ChunkW);
  assign acc_sh = acc_q >>> gba_pkg::FracW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= cmd_i.mul_en;
      if (cmd_i.acc_clr) acc_q <= '0;
      else if (prod_v_q) acc_q <= acc_q + addend;
    end
  end

  // New delay value, saturated to the delay width.
  logic signed [SumW-1:0]        rec_sum;
  logic [SumW-DELAY_WIDTH:0]     rec_hi;
  logic signed [DELAY_WIDTH-1:0] rec_sat;

  assign rec_sum = SumW'(acc_sh) + (SumW'(sample_q) <<< gba_pkg::FracW) - SumW'(d2_q);
  assign rec_hi  = rec_sum[SumW-1:DELAY_WIDTH-1];

  always_comb begin
    if ((&rec_hi) | ~(|rec_hi)) rec_sat = rec_sum[DELAY_WIDTH-1:0];
    else if (rec_sum[SumW-1]) rec_sat = {1'b1, {(DELAY_WIDTH - 1){1'b0}}};
    else rec_sat = {1'b0, {(DELAY_WIDTH - 1){1'b1}}};
  end

  // Real or imaginary part, saturated to the output width.
  logic signed [SumW-1:0] part_sum;
  logic [SumW-PW:0]       part_hi;
  logic signed [PW-1:0]   part_sat;

  assign part_sum = cmd_i.re_upd ? (SumW'(d1_q) - SumW'(acc_sh)) : SumW'(acc_sh);
  assign part_hi  = part_sum[SumW-1:PW-1];

  always_comb begin
    if ((&part_hi) | ~(|part_hi)) part_sat = part_sum[PW-1:0];
    else if (part_sum[SumW-1]) part_sat = {1'b1, {(PW - 1){1'b0}}};
    else part_sat = {1'b0, {(PW - 1){1'b1}}};
  end

  // Delay, counter and part registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q  <= '0;
      d2_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.rec_upd) begin
        d2_q  <= d1_q;
        d1_q  <= rec_sat;
        cnt_q <= sts_o.last ? '0 : cnt_q + CntW'(1);
      end else if (cmd_i.im_upd) begin
        d1_q <= '0;
        d2_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) sample_q <= sample_i;
    if (cmd_i.re_upd) re_q <= part_sat;
    if (cmd_i.im_upd) im_q <= part_sat;
  end

  // Square root, one result bit per step.
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [RemW+1:0]  rem4, trial;

  assign rem4  = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_upd) begin
      rad_q  <= acc_q[RadW-1:0];
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_en) begin
      rad_q <= rad_q << 2;
      if (rem4 >= trial) begin
        rem_q  <= RemW'(rem4 - trial);
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= RemW'(rem4);
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  // CORDIC vectoring for the phase, one rotation per step.
  logic signed [CW-1:0] cx_q, cy_q, re_w, im_w, sx, sy;
  logic signed [AW-1:0] cz_q, ang;
  logic                 czero_q;

  assign re_w = CW'(re_q);
  assign im_w = CW'(im_q);
  assign sx   = cx_q >>> cmd_i.cordic_i;
  assign sy   = cy_q >>> cmd_i.cordic_i;
  assign ang  = signed'(AW'(gba_pkg::atan_lut(cmd_i.cordic_i)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_upd) begin
      czero_q <= (re_q == '0) && (im_q == '0);
      if (re_q[PW-1]) begin
        cx_q <= -re_w;
        cy_q <= -im_w;
        cz_q <= im_q[PW-1] ? AW'(-gba_pkg::HalfTurn) : AW'(gba_pkg::HalfTurn);
      end else begin
        cx_q <= re_w;
        cy_q <= im_w;
        cz_q <= '0;
      end
    end else if (cmd_i.cordic_en) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + sy;
        cy_q <= cy_q - sx;
        cz_q <= cz_q + ang;
      end else begin
        cx_q <= cx_q - sy;
        cy_q <= cy_q + sx;
        cz_q <= cz_q - ang;
      end
    end
  end

  // Round the angle to centidegrees and clamp it.
  logic signed [AW-1:0]                 z_rnd;
  logic signed [gba_pkg::PhaseW-1:0]    phase_val;
  logic [gba_pkg::MagW-1:0]             mag_val;

  assign z_rnd = (cz_q + AW'(128)) >>> 8;

  always_comb begin
    if (czero_q) phase_val = '0;
    else if (z_rnd > AW'(gba_pkg::PhaseMax)) phase_val = gba_pkg::PhaseW'(gba_pkg::PhaseMax);
    else if (z_rnd < AW'(-gba_pkg::PhaseMax)) phase_val = gba_pkg::PhaseW'(-gba_pkg::PhaseMax);
    else phase_val = z_rnd[gba_pkg::PhaseW-1:0];
  end

  assign mag_val = root_q[RootW-1] ? {gba_pkg::MagW{1'b1}} : root_q[gba_pkg::MagW-1:0];

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      real_part_o      <= re_q;
      imag_part_o      <= im_q;
      magnitude_o      <= mag_val;
      phase_centideg_o <= phase_val;
    end
  end

endmodule

FILE: rtl/core/goertzel_bin_analyzer_top.sv
// Goertzel single-bin analyser: takes one ADC sample per item and gives one result per block.
// Each sample item is accepted in the idle state, and the input stalls until it is done; its
// pace is set by the shared 25 x 25 multiplier that forms the coefficient product chunk by
// chunk. The last sample of a block then also takes two more chunked products for the real
// and imaginary parts, eight partial products for the squared magnitude, and a 48-step
// bit-serial square root that also runs the 16 CORDIC phase steps. A finished result waits
// in the output register while the next block's samples are taken in. Configuration is
// written over the APB port.
module goertzel_bin_analyzer_top #(
  parameter int unsigned MAX_BLOCK   = gba_pkg::MaxBlockDef,
  parameter int unsigned DELAY_WIDTH = gba_pkg::DelayWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [gba_pkg::SampleW-1:0] sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [gba_pkg::PartW-1:0]   real_part_o,
  output logic signed [gba_pkg::PartW-1:0]   imag_part_o,
  output logic [gba_pkg::MagW-1:0]           magnitude_o,
  output logic signed [gba_pkg::PhaseW-1:0]  phase_centideg_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gba_pkg::PaddrW-1:0]         paddr,
  input  logic [gba_pkg::PdataW-1:0]         pwdata,
  output logic [gba_pkg::PdataW-1:0]         prdata,
  output logic                               pready
);

  gba_pkg::cfg_t cfg;
  gba_pkg::cmd_t cmd;
  gba_pkg::sts_t sts;

  gba_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gba_ctrl #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gba_dp #(
    .MAX_BLOCK   (MAX_BLOCK),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .sample_i         (sample_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .real_part_o      (real_part_o),
    .imag_part_o      (imag_part_o),
    .magnitude_o      (magnitude_o),
    .phase_centideg_o (phase_centideg_o)
  );

  // An accepted item starts its coefficient product in the next cycle.
  a_accept_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> cmd.mul_en)
    else $error("accepted item did not start the multiplier");

  // A loaded result is offered on the output in the next cycle.
  a_load_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");

  // A sample that does not end its block frees the input at once.
  a_mid_block_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rec_upd && !sts.last) |=> !in_stall_o)
    else $error("input still stalled after a mid-block sample");

endmodule
